@@ src/vdpw_pkg.sv @@
`timescale 1ns / 1ps

package vdpw_pkg;

    localparam int unsigned INDEX_W    = 11;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned LBYTES_W   = 11;
    localparam int unsigned LCOUNT_W   = 11;
    localparam int unsigned STRIDE_W   = 16;
    localparam int unsigned LABEL_W    = 4;
    localparam int unsigned CFG_IDX_W  = 3;

    // Opcode words of the capture program
    localparam logic [WORD_W-1:0] OP_SYNC_EVEN = 32'h8000_8004;
    localparam logic [WORD_W-1:0] OP_SYNC_ODD  = 32'h8000_800C;
    localparam logic [WORD_W-1:0] OP_SYNC_FM1  = 32'h8000_0006;
    localparam logic [WORD_W-1:0] OP_WRITE     = 32'h1C00_0000;
    localparam logic [WORD_W-1:0] OP_JMP_RESET = 32'h70F0_0000;
    localparam logic [WORD_W-1:0] OP_JMP_IRQ   = 32'h7100_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUFFER_BASE  = 3'd0,
        REG_LINE_BYTES   = 3'd1,
        REG_LINE_COUNT   = 3'd2,
        REG_LINE_STRIDE  = 3'd3,
        REG_FRAME_LABEL  = 3'd4,
        REG_PROGRAM_BASE = 3'd5,
        REG_NEXT_PROGRAM = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [WORD_W-1:0]   buffer_base;
        logic [LBYTES_W-1:0] line_bytes;
        logic [LCOUNT_W-1:0] line_count;
        logic [STRIDE_W-1:0] line_stride;
        logic [LABEL_W-1:0]  frame_label;
        logic [WORD_W-1:0]   program_base;
        logic [WORD_W-1:0]   next_program_address;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] opcode_word;
        logic [WORD_W-1:0] operand_word;
        logic              is_last;
        logic              out_of_range;
    } result_t;

endpackage

@@ src/video_dma_program_word_generator.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     instr_index
// out       output     out_valid / out_stall   opcode_word, operand_word, is_last, out_of_range
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An accepted index passes through the index register, then through the decode
// (one 11x16 multiply and one 32-bit add) into the result register, and from
// there to the out ports. One transaction per cycle sustained while out does not
// stall. Reset restores the register defaults and empties both stages.
// A stall on out backs up through the pipe; in_stall rises only when both
// stages hold a transaction that cannot move.

module video_dma_program_word_generator
    import vdpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [INDEX_W-1:0]   instr_index,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    opcode_word,
    output logic [WORD_W-1:0]    operand_word,
    output logic                 is_last,
    output logic                 out_of_range,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    cfg_t               cfg;
    result_t            dec_result;

    logic               idx_valid_reg;
    logic               idx_valid_next;
    logic [INDEX_W-1:0] idx_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    result_t            res_reg;

    logic               res_advance;
    logic               idx_advance;
    logic               in_take;

    // Configuration is always accepted; the user must write it only while idle (unchecked).
    assign cfg_ready = 1'b1;

    vdpw_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vdpw_decode u_decode (
        .cfg    (cfg),
        .index  (idx_reg),
        .result (dec_result)
    );

    // Result register moves when empty or when out takes it.
    assign res_advance = !res_valid_reg || !out_stall;
    // Index register moves when empty or when its item can go on.
    assign idx_advance = !idx_valid_reg || res_advance;
    assign in_stall    = !idx_advance;
    assign in_take     = in_valid && idx_advance;

    always_comb
    begin
        idx_valid_next = idx_valid_reg;
        res_valid_next = res_valid_reg;
        if (idx_advance)
        begin
            idx_valid_next = in_valid;
        end
        if (res_advance)
        begin
            res_valid_next = idx_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_valid_reg <= idx_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            idx_reg <= instr_index;
        end
        if (res_advance && idx_valid_reg)
        begin
            res_reg <= dec_result;
        end
    end

    assign out_valid    = res_valid_reg;
    assign opcode_word  = res_reg.opcode_word;
    assign operand_word = res_reg.operand_word;
    assign is_last      = res_reg.is_last;
    assign out_of_range = res_reg.out_of_range;

    a_last_excl_oor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_last && out_of_range))
        else $error("is_last and out_of_range both set");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (opcode_word == '0 && operand_word == '0))
        else $error("out_of_range result carries nonzero words");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_valid_reg && res_valid_reg && out_stall) |-> in_stall)
        else $error("input taken while pipe is full and blocked");

    a_idx_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_valid_reg && res_advance) |=> res_valid_reg)
        else $error("transaction lost between index and result stages");

endmodule

@@ src/vdpw_cfg_regs.sv @@
`timescale 1ns / 1ps

module vdpw_cfg_regs
    import vdpw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_BUFFER_BASE:  cfg_next.buffer_base          = wr_data;
                REG_LINE_BYTES:   cfg_next.line_bytes           = wr_data[LBYTES_W-1:0];
                REG_LINE_COUNT:   cfg_next.line_count           = wr_data[LCOUNT_W-1:0];
                REG_LINE_STRIDE:  cfg_next.line_stride          = wr_data[STRIDE_W-1:0];
                REG_FRAME_LABEL:  cfg_next.frame_label          = wr_data[LABEL_W-1:0];
                REG_PROGRAM_BASE: cfg_next.program_base         = wr_data;
                REG_NEXT_PROGRAM: cfg_next.next_program_address = wr_data;
                default:          cfg_next = cfg_reg;  // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buffer_base          <= '0;
            cfg_reg.line_bytes           <= 11'd1280;
            cfg_reg.line_count           <= 11'd480;
            cfg_reg.line_stride          <= 16'd1280;
            cfg_reg.frame_label          <= '0;
            cfg_reg.program_base         <= '0;
            cfg_reg.next_program_address <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/vdpw_decode.sv @@
`timescale 1ns / 1ps

module vdpw_decode
    import vdpw_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [INDEX_W-1:0] index,
    output result_t            result
);

    localparam int unsigned CW = INDEX_W + 1;
    localparam int unsigned PW = INDEX_W + STRIDE_W;

    logic [CW-1:0]      idx;
    logic [CW-1:0]      half;
    logic [CW-1:0]      odd_sync;
    logic [CW-1:0]      odd_fm1;
    logic [CW-1:0]      jmp_reset;
    logic [CW-1:0]      jmp_irq;
    logic [CW-1:0]      even_line;
    logic [CW-1:0]      odd_line;
    logic [INDEX_W-1:0] line_num;
    logic [PW-1:0]      line_offset;
    logic [WORD_W-1:0]  line_addr;
    logic [WORD_W-1:0]  jump_addr;
    logic [WORD_W-1:0]  write_op;

    assign idx       = {1'b0, index};
    assign half      = {2'b00, cfg.line_count[LCOUNT_W-1:1]};
    assign odd_sync  = half + CW'(2);
    assign odd_fm1   = half + CW'(3);
    assign jmp_reset = {half[CW-2:0], 1'b0} + CW'(4);
    assign jmp_irq   = {half[CW-2:0], 1'b0} + CW'(5);

    // Frame line: 2i in the even field, 2i+1 in the odd field
    assign even_line = (idx - CW'(2)) << 1;
    assign odd_line  = ((idx - odd_fm1 - CW'(1)) << 1) | CW'(1);

    always_comb
    begin
        if (idx < odd_sync)
        begin
            line_num = even_line[INDEX_W-1:0];
        end
        else
        begin
            line_num = odd_line[INDEX_W-1:0];
        end
    end

    assign line_offset = PW'(line_num) * PW'(cfg.line_stride);
    assign line_addr   = cfg.buffer_base + WORD_W'(line_offset);
    assign jump_addr   = cfg.program_base + WORD_W'({jmp_irq, 3'b000});
    assign write_op    = OP_WRITE | WORD_W'(cfg.line_bytes);

    always_comb
    begin
        result = '0;
        if (idx == CW'(0))
        begin
            result.opcode_word = OP_SYNC_EVEN;
        end
        else if (idx == CW'(1))
        begin
            result.opcode_word = OP_SYNC_FM1;
        end
        else if (idx < odd_sync)
        begin
            result.opcode_word  = write_op;
            result.operand_word = line_addr;
        end
        else if (idx == odd_sync)
        begin
            result.opcode_word = OP_SYNC_ODD;
        end
        else if (idx == odd_fm1)
        begin
            result.opcode_word = OP_SYNC_FM1;
        end
        else if (idx < jmp_reset)
        begin
            result.opcode_word  = write_op;
            result.operand_word = line_addr;
        end
        else if (idx == jmp_reset)
        begin
            result.opcode_word  = OP_JMP_RESET;
            result.operand_word = jump_addr;
        end
        else if (idx == jmp_irq)
        begin
            result.opcode_word  = OP_JMP_IRQ | {8'h00, 4'h0, cfg.frame_label, 16'h0000};
            result.operand_word = cfg.next_program_address;
            result.is_last      = 1'b1;
        end
        else
        begin
            result.out_of_range = 1'b1;
        end
    end

endmodule
